/* rtl/srht_pkg.sv */
`default_nettype none

package srht_pkg;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CORNER_X = 2'd0,
        CFG_CORNER_Y = 2'd1,
        CFG_WIDTH    = 2'd2,
        CFG_HEIGHT   = 2'd3
    } t_cfg_idx;

    // differences of coordinates and far corners need two bits over a coordinate
    localparam int DIFF_EXTRA = 2;

endpackage

`default_nettype wire

/* rtl/srht_seg_if.sv */
`default_nettype none

interface srht_seg_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y, input end_x,
                    input end_y, output ready);
endinterface

`default_nettype wire

/* rtl/srht_hit_if.sv */
`default_nettype none

interface srht_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, output hit, input ready);
    modport sink   (input valid, input hit, output ready);
endinterface

`default_nettype wire

/* rtl/srht_edge.sv */
`default_nettype none

// crossing test of the segment against one axis-aligned rectangle edge
// stage 2: products, stage 3: numerators and denominator, then compare
module srht_edge #(
    parameter int COORD_BITS = 16
) (
    input  wire                                                   i_clk,
    input  wire                                                   i_en,
    input  wire        [COORD_BITS-2:0]                           i_len,
    input  wire signed [COORD_BITS+srht_pkg::DIFF_EXTRA-1:0]      i_dv,
    input  wire signed [COORD_BITS+srht_pkg::DIFF_EXTRA-1:0]      i_nv,
    input  wire signed [COORD_BITS+srht_pkg::DIFF_EXTRA-1:0]      i_sx,
    input  wire signed [COORD_BITS+srht_pkg::DIFF_EXTRA-1:0]      i_sy,
    input  wire signed [COORD_BITS+srht_pkg::DIFF_EXTRA-1:0]      i_ox,
    input  wire signed [COORD_BITS+srht_pkg::DIFF_EXTRA-1:0]      i_oy,
    output logic                                                  o_cross
);
    localparam int D = COORD_BITS + srht_pkg::DIFF_EXTRA;
    localparam int M = COORD_BITS + D;
    localparam int P = 2 * D + 1;

    logic signed [COORD_BITS-1:0] len_s;
    logic signed [M-1:0]          r_pd;
    logic signed [M-1:0]          r_pa;
    logic signed [2*D-1:0]        r_p1;
    logic signed [2*D-1:0]        r_p2;
    logic signed [M-1:0]          r_den;
    logic signed [M-1:0]          r_na;
    logic signed [P-1:0]          r_nb;
    logic signed [P-1:0]          den_x;
    logic signed [P-1:0]          na_x;

    assign len_s = signed'({1'b0, i_len});

    // products of edge length and of the cross terms
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pd <= len_s * i_dv;
            r_pa <= len_s * i_nv;
            r_p1 <= i_sx * i_oy;
            r_p2 <= i_sy * i_ox;
        end
    end

    // denominator and the two numerators
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den <= r_pd;
            r_na  <= r_pa;
            r_nb  <= P'(r_p1) - P'(r_p2);
        end
    end

    // ua and ub within [0,1], parallel edge never crosses
    always_comb begin
        den_x = P'(r_den);
        na_x  = P'(r_na);
        if (den_x == '0) begin
            o_cross = 1'b0;
        end else if (den_x > 0) begin
            o_cross = (na_x >= 0) && (na_x <= den_x) && (r_nb >= 0) && (r_nb <= den_x);
        end else begin
            o_cross = (na_x <= 0) && (na_x >= den_x) && (r_nb <= 0) && (r_nb >= den_x);
        end
    end
endmodule

`default_nettype wire

/* rtl/segment_rectangle_hit_test.sv */
`default_nettype none

// channel   | direction | payload                              | handshake
// i_seg     | in        | start_x, start_y, end_x, end_y       | valid / ready
// o_hit     | out       | hit                                  | valid / ready
// i_cfg_*   | in        | i_cfg_idx, i_cfg_data                | i_cfg_we, no wait
//
// one segment per cycle while the output does not stall; a result passes through the stages below in order
// stages: differences and point test, products, numerators, compare into output
// reset clears the valid bits and the rectangle registers to zero
// a stalled output freezes the whole pipeline, input ready drops in the same cycle
module segment_rectangle_hit_test #(
    parameter int COORD_BITS = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    srht_seg_if.sink                              i_seg,
    srht_hit_if.source                            o_hit,
    input  wire                                   i_cfg_we,
    input  wire [srht_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  wire [COORD_BITS-1:0]                  i_cfg_data
);
    localparam int D = COORD_BITS + srht_pkg::DIFF_EXTRA;

    // rectangle registers
    logic signed [COORD_BITS-1:0] r_cx;
    logic signed [COORD_BITS-1:0] r_cy;
    logic        [COORD_BITS-2:0] r_w;
    logic        [COORD_BITS-2:0] r_h;

    // pipeline control
    logic en;
    logic r_v1, r_v2, r_v3, r_v4;

    // stage 1 combinational
    logic signed [COORD_BITS:0] far_x;
    logic signed [COORD_BITS:0] far_y;
    logic signed [D-1:0] px, py, qx, qy;
    logic signed [D-1:0] lox, loy, hix, hiy;
    logic                n_in;

    // stage 1 registers, point-test delay line and output signals
    logic signed [D-1:0] r_sx, r_sy, r_nsy;
    logic signed [D-1:0] r_ox0, r_ox1, r_nox0, r_nox1;
    logic signed [D-1:0] r_oy0, r_oy1;
    logic                r_in1, r_in2, r_in3;
    logic                r_hit;
    logic [3:0]          edge_cross;
    logic                n_hit;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_w  <= '0;
            r_h  <= '0;
        end else if (i_cfg_we) begin
            unique case (srht_pkg::t_cfg_idx'(i_cfg_idx))
                srht_pkg::CFG_CORNER_X: r_cx <= signed'(i_cfg_data);
                srht_pkg::CFG_CORNER_Y: r_cy <= signed'(i_cfg_data);
                srht_pkg::CFG_WIDTH:    r_w  <= i_cfg_data[COORD_BITS-2:0];
                srht_pkg::CFG_HEIGHT:   r_h  <= i_cfg_data[COORD_BITS-2:0];
            endcase
        end
    end

    // the pipeline moves unless the output holds an untaken result
    assign en          = !r_v4 || o_hit.ready;
    assign i_seg.ready = en;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_seg.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // far corner and point-in-rectangle test
    always_comb begin
        far_x = (COORD_BITS+1)'(r_cx) + (COORD_BITS+1)'(signed'({1'b0, r_w}));
        far_y = (COORD_BITS+1)'(r_cy) + (COORD_BITS+1)'(signed'({1'b0, r_h}));
        px    = D'(i_seg.start_x);
        py    = D'(i_seg.start_y);
        qx    = D'(i_seg.end_x);
        qy    = D'(i_seg.end_y);
        lox   = D'(r_cx);
        loy   = D'(r_cy);
        hix   = D'(far_x);
        hiy   = D'(far_y);
        n_in  = ((px >= lox) && (px <= hix) && (py >= loy) && (py <= hiy)) ||
                ((qx >= lox) && (qx <= hix) && (qy >= loy) && (qy <= hiy));
    end

    // stage 1: direction and offsets from the corners
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx   <= qx - px;
            r_sy   <= qy - py;
            r_nsy  <= py - qy;
            r_ox0  <= px - lox;
            r_ox1  <= px - hix;
            r_nox0 <= lox - px;
            r_nox1 <= hix - px;
            r_oy0  <= py - loy;
            r_oy1  <= py - hiy;
            r_in1  <= n_in;
        end
    end

    // bottom edge
    srht_edge #(.COORD_BITS(COORD_BITS)) u_edge_bottom (
        .i_clk (i_clk), .i_en (en), .i_len (r_w), .i_dv (r_nsy), .i_nv (r_oy0),
        .i_sx (r_sx), .i_sy (r_sy), .i_ox (r_ox0), .i_oy (r_oy0), .o_cross (edge_cross[0])
    );

    // top edge
    srht_edge #(.COORD_BITS(COORD_BITS)) u_edge_top (
        .i_clk (i_clk), .i_en (en), .i_len (r_w), .i_dv (r_nsy), .i_nv (r_oy1),
        .i_sx (r_sx), .i_sy (r_sy), .i_ox (r_ox0), .i_oy (r_oy1), .o_cross (edge_cross[1])
    );

    // left edge
    srht_edge #(.COORD_BITS(COORD_BITS)) u_edge_left (
        .i_clk (i_clk), .i_en (en), .i_len (r_h), .i_dv (r_sx), .i_nv (r_nox0),
        .i_sx (r_sx), .i_sy (r_sy), .i_ox (r_ox0), .i_oy (r_oy0), .o_cross (edge_cross[2])
    );

    // right edge
    srht_edge #(.COORD_BITS(COORD_BITS)) u_edge_right (
        .i_clk (i_clk), .i_en (en), .i_len (r_h), .i_dv (r_sx), .i_nv (r_nox1),
        .i_sx (r_sx), .i_sy (r_sy), .i_ox (r_ox1), .i_oy (r_oy0), .o_cross (edge_cross[3])
    );

    // point test rides along with the edge stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in2 <= r_in1;
            r_in3 <= r_in2;
        end
    end

    // output register
    assign n_hit = r_in3 || (|edge_cross);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= n_hit;
        end
    end

    assign o_hit.valid = r_v4;
    assign o_hit.hit   = r_hit;

    // a transaction enters stage one
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_seg.valid && i_seg.ready |=> r_v1)
        else $error("accepted transaction missing from stage one");

    // last edge stage reaches the output
    a_leave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && en |=> o_hit.valid)
        else $error("result lost between stage three and output");

    // a stall freezes every valid bit
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable({r_v1, r_v2, r_v3, r_v4}))
        else $error("pipeline moved during stall");

    // an endpoint inside always reports a hit
    a_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_in3 && en |=> o_hit.hit)
        else $error("endpoint inside rectangle without hit");
endmodule

`default_nettype wire
